/* hdl/fmfbe_pkg.sv */
// Package for the FM F-number/block encoder.
// Holds field types, register address bases and the block-fit thresholds.
// No dependencies.
`timescale 1ns / 1ps

package fmfbe_pkg;

    localparam int NUM_CHANNELS_DEF = 9;

    localparam int FREQ_W  = 17;
    localparam int FNUM_W  = 10;
    localparam int BLK_W   = 3;
    localparam int NUM_W   = 27;
    localparam int RECIP_W = 11;

    localparam int FREQ_MIN    = 320;      // 20 Hz in sixteenths
    localparam int FREQ_MAX    = 99328;    // 6208 Hz in sixteenths
    localparam int CHIP_RATE   = 49716;
    localparam int DIVISOR     = 2 * CHIP_RATE;
    localparam int FNUM_MAX    = 1023;
    // F-number fits when (f16 << (17-blk)) < FIT_LIMIT
    localparam int FIT_LIMIT   = (FNUM_MAX + 1) * DIVISOR - CHIP_RATE;
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP       = (1 << RECIP_SHIFT) / DIVISOR;

    localparam logic [7:0] ADDR_LOW_BASE  = 8'hA0;
    localparam logic [7:0] ADDR_HIGH_BASE = 8'hB0;

    typedef logic [FREQ_W-1:0] freq_t;
    typedef logic [FNUM_W-1:0] fnum_t;
    typedef logic [BLK_W-1:0]  blk_t;
    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [3:0]        chan_t;

    // smallest frequency (sixteenths) that no longer fits in block b
    function automatic freq_t block_limit(input blk_t b);
        int s;
        s = 17 - int'(b);
        return freq_t'((FIT_LIMIT + (1 << s) - 1) >> s);
    endfunction

endpackage

/* hdl/fmfbe_in_if.sv */
// Note-event channel interface: valid/ready with channel, frequency and key-on.
// Depends on fmfbe_pkg.
`timescale 1ns / 1ps

interface fmfbe_in_if
    import fmfbe_pkg::*;
();
    logic  valid;
    logic  ready;
    chan_t channel;
    freq_t freq_sixteenths;
    logic  key_on;

    modport source (output valid, channel, freq_sixteenths, key_on, input ready);
    modport sink   (input valid, channel, freq_sixteenths, key_on, output ready);
endinterface

/* hdl/fmfbe_out_if.sv */
// Register-write channel interface: valid/ready with address, data and last flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface fmfbe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last_write;

    modport source (output valid, reg_addr, reg_data, last_write, input ready);
    modport sink   (input valid, reg_addr, reg_data, last_write, output ready);
endinterface

/* hdl/fm_fnum_block_encoder_top.sv */
// FM voice frequency encoder: note event in, two chip register writes out.
// Depends on fmfbe_pkg, fmfbe_in_if and fmfbe_out_if.
`timescale 1ns / 1ps

// Usage
//   note  : sink channel, one transaction per note event (channel, frequency in
//           1/16 Hz, key-on). Channels at or above NUM_CHANNELS are swallowed
//           and produce nothing.
//   regwr : source channel, two transactions per accepted note: first
//           0xA0+ch with F-number[7:0], then 0xB0+ch with key-on, block and
//           F-number[9:8]; last_write marks the second.
//   Output: the first write is valid once the note reaches the output
//           register; the second follows in the next cycle if regwr is ready.
//   Throughput: sustained rate is set by the two writes per note leaving
//           through the single output register. The 4-stage pipe (input,
//           block select, reciprocal multiply, remainder fix) takes a note
//           every cycle while it has a free slot.
//   Stall: when regwr is not ready the pipe fills up and note.ready drops
//           once every stage holds a transaction; nothing is lost.
//   Reset: rst_n clears all valid flags; the pipe comes up empty.
module fm_fnum_block_encoder_top
    import fmfbe_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fmfbe_in_if.sink     note,
    fmfbe_out_if.source  regwr
);

    // stage 1: input register
    logic  v1_reg, v1_next;
    chan_t ch1_reg;
    freq_t f1_reg;
    logic  kon1_reg;

    // stage 2: block and numerator
    logic  v2_reg, v2_next;
    chan_t ch2_reg;
    logic  kon2_reg;
    blk_t  blk2_reg;
    num_t  num2_reg;

    // stage 3: quotient estimate
    logic  v3_reg, v3_next;
    chan_t ch3_reg;
    logic  kon3_reg;
    blk_t  blk3_reg;
    num_t  num3_reg;
    fnum_t qest3_reg;

    // output stage
    logic  ov_reg, ov_next;
    logic  phase_reg, phase_next;
    chan_t cho_reg;
    logic  kono_reg;
    blk_t  blko_reg;
    fnum_t fnumo_reg;

    logic en1, en2, en3, out_en;
    logic ch_ok;

    freq_t f_clamp;
    blk_t  blk_sel;
    num_t  num_calc;

    logic [NUM_W+RECIP_W-1:0] prod;
    num_t                     rem;
    fnum_t                    fnum_fix;

    assign out_en = !ov_reg || (regwr.ready && phase_reg);
    assign en3    = !v3_reg || out_en;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;

    assign note.ready = en1;
    assign ch_ok = {1'b0, note.channel} < 5'(NUM_CHANNELS);

    // clamp, block select, numerator
    always_comb
    begin
        f_clamp = f1_reg;
        if (f1_reg < freq_t'(FREQ_MIN))
        begin
            f_clamp = freq_t'(FREQ_MIN);
        end
        else if (f1_reg > freq_t'(FREQ_MAX))
        begin
            f_clamp = freq_t'(FREQ_MAX);
        end

        blk_sel = blk_t'(7);
        for (int b = 7; b >= 0; b--)
        begin
            if (f_clamp < block_limit(blk_t'(b)))
            begin
                blk_sel = blk_t'(b);
            end
        end

        // shift by 17 - blk = 10 + (7 - blk)
        num_calc = (num_t'(f_clamp) << (5'd10 + {2'b00, ~blk_sel})) + num_t'(CHIP_RATE);
    end

    // reciprocal estimate is exact or one low
    assign prod = num2_reg * RECIP_W'(RECIP);

    always_comb
    begin
        rem = num3_reg - num_t'(num_t'(qest3_reg) * num_t'(DIVISOR));
        fnum_fix = qest3_reg;
        if (rem >= num_t'(DIVISOR))
        begin
            fnum_fix = qest3_reg + fnum_t'(1);
        end
    end

    always_comb
    begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        ov_next = ov_reg;
        phase_next = phase_reg;
        if (en1)
        begin
            v1_next = note.valid && ch_ok;
        end
        if (en2)
        begin
            v2_next = v1_reg;
        end
        if (en3)
        begin
            v3_next = v2_reg;
        end
        if (out_en)
        begin
            ov_next = v3_reg;
            phase_next = 1'b0;
        end
        else if (regwr.ready)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            v3_reg    <= v3_next;
            ov_reg    <= ov_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ch1_reg  <= note.channel;
            f1_reg   <= note.freq_sixteenths;
            kon1_reg <= note.key_on;
        end
        if (en2)
        begin
            ch2_reg  <= ch1_reg;
            kon2_reg <= kon1_reg;
            blk2_reg <= blk_sel;
            num2_reg <= num_calc;
        end
        if (en3)
        begin
            ch3_reg   <= ch2_reg;
            kon3_reg  <= kon2_reg;
            blk3_reg  <= blk2_reg;
            num3_reg  <= num2_reg;
            qest3_reg <= fnum_t'(prod[NUM_W+RECIP_W-1:RECIP_SHIFT]);
        end
        if (out_en)
        begin
            cho_reg   <= ch3_reg;
            kono_reg  <= kon3_reg;
            blko_reg  <= blk3_reg;
            fnumo_reg <= fnum_fix;
        end
    end

    assign regwr.valid      = ov_reg;
    assign regwr.last_write = phase_reg;
    assign regwr.reg_addr   = phase_reg ? (ADDR_HIGH_BASE + {4'b0, cho_reg})
                                        : (ADDR_LOW_BASE + {4'b0, cho_reg});
    assign regwr.reg_data   = phase_reg ? {2'b00, kono_reg, blko_reg, fnumo_reg[9:8]}
                                        : fnumo_reg[7:0];

endmodule
